/* rtl/elca_pkg.sv */
// elca_pkg: shared types and constants for the even-order legendre accumulator
// holds the sequencer state type and the reciprocal table for the recurrence
// no dependencies
package elca_pkg;

    // sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL,
        S_COMB,
        S_RCP,
        S_NEXT,
        S_ARD,
        S_AWR,
        S_ERD,
        S_EWAIT
    } t_state;

    // fixed field widths
    localparam int DOT_W  = 17;
    localparam int WGT_W  = 24;
    localparam int ACC_W  = 48;
    localparam int IDX_W  = 3;
    localparam int CFG_W  = 4;
    localparam int RCP_W  = 24;
    localparam int ORD_W  = 5;

    // datapath widths
    localparam int P_W    = 34;
    localparam int XA_W   = 51;
    localparam int T_W    = 56;
    localparam int NV_W   = 38;
    localparam int CON_W  = 32;

    localparam logic [15:0] ONE_Q15 = 16'd32768;

    // rounded Q24 reciprocal of the recurrence order m
    function automatic logic [RCP_W-1:0] recip(input logic [ORD_W-1:0] m);
        logic [RCP_W-1:0] r;
        begin
            case (m)
                5'd2:    r = 24'd8388608;
                5'd3:    r = 24'd5592405;
                5'd4:    r = 24'd4194304;
                5'd5:    r = 24'd3355443;
                5'd6:    r = 24'd2796203;
                5'd7:    r = 24'd2396745;
                5'd8:    r = 24'd2097152;
                5'd9:    r = 24'd1864135;
                5'd10:   r = 24'd1677722;
                5'd11:   r = 24'd1525201;
                5'd12:   r = 24'd1398101;
                5'd13:   r = 24'd1290555;
                5'd14:   r = 24'd1198373;
                5'd15:   r = 24'd1118481;
                5'd16:   r = 24'd1048576;
                5'd17:   r = 24'd986895;
                5'd18:   r = 24'd932068;
                5'd19:   r = 24'd883011;
                5'd20:   r = 24'd838861;
                5'd21:   r = 24'd798915;
                5'd22:   r = 24'd762601;
                5'd23:   r = 24'd729444;
                5'd24:   r = 24'd699051;
                5'd25:   r = 24'd671089;
                5'd26:   r = 24'd645278;
                5'd27:   r = 24'd621378;
                5'd28:   r = 24'd599186;
                5'd29:   r = 24'd578525;
                5'd30:   r = 24'd559241;
                5'd31:   r = 24'd541201;
                default: r = '0;
            endcase
            return r;
        end
    endfunction

endpackage

/* rtl/elca_ram.sv */
// elca_ram: generic simple dual-port ram with registered read
// one write port and one read port, read data held when no read is issued
// no dependencies
module elca_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 8
) (
    input  logic                                 i_clk,
    input  logic                                 i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                     i_wdata,
    input  logic                                 i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                     o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // storage write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/even_legendre_coef_accumulator_top.sv */
// Even-order legendre coefficient accumulator. Each valid pair (tuser set) adds
// weight * P_2k(|dot|) into accumulator k for k below the coefficient count n;
// a transaction with tlast set then streams all n accumulators out (tlast on
// the final one) and clears them. One item is worked at a time. For a valid
// pair, coefficient 0 takes only a read and a write of the accumulator ram;
// each further coefficient takes two recurrence steps (multiply, combine,
// reciprocal, next) on the shared multiply chain, then that ram read and write;
// when |dot| is one each further coefficient is only the ram read and write.
// A flush reads each coefficient into the output register, waiting on stalls.
// depends on elca_pkg and elca_ram
module even_legendre_coef_accumulator_top #(
    parameter int MAX_COEFS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // cfg write: coef_count
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [elca_pkg::CFG_W-1:0] i_cfg_data,
    // input stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [47:0] i_s_tdata,   // dot_product[16:0], pair_weight[40:17], zero pad
    input  logic        i_s_tuser,   // pair_valid
    input  logic        i_s_tlast,   // flush
    // result stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [elca_pkg::ACC_W-1:0] o_m_tdata,  // coef_value
    output logic [elca_pkg::IDX_W-1:0] o_m_tuser,  // coef_index
    output logic        o_m_tlast    // last_coef
);
    import elca_pkg::*;

    localparam int AW = (MAX_COEFS > 1) ? $clog2(MAX_COEFS) : 1;
    localparam int CW = $clog2(MAX_COEFS + 1);
    localparam int MW = $clog2(2 * MAX_COEFS);

    t_state r_state, n_state;

    logic [15:0]           r_x;
    logic                  r_one;
    logic signed [WGT_W-1:0] r_w;
    logic                  r_fl;
    logic [CW-1:0]         r_n;
    logic [CW-1:0]         r_k;
    logic [MW-1:0]         r_m;
    logic                  r_odd;
    logic signed [P_W-1:0] r_prev, r_cur, r_pe;
    logic signed [XA_W-1:0] r_xa;
    logic signed [NV_W-1:0] r_nv;
    logic signed [NV_W+RCP_W:0] r_q;
    logic signed [CON_W-1:0] r_con;
    logic [MAX_COEFS-1:0]  r_vld;
    logic [CFG_W-1:0]      r_cfg;

    logic                  r_ov;
    logic [ACC_W-1:0]      r_od;
    logic [IDX_W-1:0]      r_oi;
    logic                  r_ol;

    logic s_acc, out_free, k_last;
    logic ram_we, ram_re;
    logic [ACC_W-1:0] ram_rdata, acc_old, acc_new;

    // input decode
    logic signed [DOT_W-1:0] in_dot;
    logic [DOT_W-1:0]        dot_abs;
    logic [15:0]             x_in;
    logic [CW-1:0]           n_in;

    assign in_dot  = i_s_tdata[DOT_W-1:0];
    assign dot_abs = in_dot[DOT_W-1] ? DOT_W'(-in_dot) : DOT_W'(in_dot);
    assign x_in    = (dot_abs >= DOT_W'(ONE_Q15)) ? ONE_Q15 : dot_abs[15:0];

    always_comb begin
        if (r_cfg == '0) begin
            n_in = CW'(1);
        end else if ({1'b0, r_cfg} > 5'(MAX_COEFS)) begin
            n_in = CW'(MAX_COEFS);
        end else begin
            n_in = CW'(r_cfg);
        end
    end

    assign s_acc    = i_s_tvalid && o_s_tready;
    assign out_free = !r_ov || i_m_tready;
    assign k_last   = (r_k == r_n - CW'(1));

    // recurrence datapath
    logic signed [P_W-1:0]   step_a, step_b, p_new;
    logic signed [T_W-1:0]   t_val, t_rnd;
    logic signed [T_W-1:0]   t_mo, t_xa, t_m1, t_b;
    logic signed [NV_W+RCP_W:0] q_rnd;
    logic signed [WGT_W+P_W-1:0] wp, wp_rnd;
    logic [MW:0]             m_odd;

    assign step_a = r_odd ? r_pe  : r_cur;
    assign step_b = r_odd ? r_cur : r_prev;
    assign m_odd  = {r_m, 1'b0} - (MW+1)'(1);
    assign t_mo   = T_W'(m_odd);
    assign t_m1   = T_W'(r_m - MW'(1));
    assign t_xa   = T_W'(r_xa);
    assign t_b    = T_W'(step_b);
    assign t_val  = t_mo * t_xa - ((t_m1 * t_b) <<< 15);
    assign t_rnd  = (t_val + T_W'(16384)) >>> 15;
    assign q_rnd  = (r_q + (NV_W+RCP_W+1)'(1 << 23)) >>> 24;
    assign p_new  = P_W'(q_rnd);
    assign wp     = (WGT_W+P_W)'(r_w) * (WGT_W+P_W)'(r_pe);
    assign wp_rnd = (wp + (WGT_W+P_W)'(1 << 29)) >>> 30;

    // accumulator read-modify-write with saturation
    logic signed [ACC_W:0] sum;
    assign acc_old = r_vld[r_k[AW-1:0]] ? ram_rdata : '0;
    assign sum     = $signed({acc_old[ACC_W-1], acc_old}) + (ACC_W+1)'(r_con);
    always_comb begin
        if (sum[ACC_W] != sum[ACC_W-1]) begin
            acc_new = sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        end else begin
            acc_new = sum[ACC_W-1:0];
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (s_acc) begin
                    if (i_s_tuser) n_state = S_ARD;
                    else if (i_s_tlast) n_state = S_ERD;
                end
            end
            S_MUL:  n_state = S_COMB;
            S_COMB: n_state = S_RCP;
            S_RCP:  n_state = S_NEXT;
            S_NEXT: n_state = r_odd ? S_ARD : S_MUL;
            S_ARD:  n_state = S_AWR;
            S_AWR: begin
                if (k_last) n_state = r_fl ? S_ERD : S_IDLE;
                else n_state = r_one ? S_ARD : S_MUL;
            end
            S_ERD:  n_state = S_EWAIT;
            S_EWAIT: begin
                if (out_free) n_state = k_last ? S_IDLE : S_ERD;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        o_s_tready = (r_state == S_IDLE);
        ram_re     = (r_state == S_ARD) || (r_state == S_ERD);
        ram_we     = (r_state == S_AWR);
    end

    assign o_cfg_ready = 1'b1;

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cfg   <= CFG_W'(8);
            r_vld   <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                r_cfg <= i_cfg_data;
            end
            if (ram_we) begin
                r_vld[r_k[AW-1:0]] <= 1'b1;
            end
            if (r_state == S_EWAIT && out_free) begin
                r_ov <= 1'b1;
                if (k_last) r_vld <= '0;
            end else if (i_m_tready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (s_acc) begin
                    r_x    <= x_in;
                    r_one  <= (x_in == ONE_Q15);
                    r_w    <= i_s_tdata[DOT_W+WGT_W-1:DOT_W];
                    r_fl   <= i_s_tlast;
                    r_n    <= n_in;
                    r_k    <= '0;
                    r_odd  <= 1'b0;
                    r_con  <= CON_W'($signed(i_s_tdata[DOT_W+WGT_W-1:DOT_W]));
                    r_prev <= P_W'(1 << 30);
                    r_cur  <= $signed({{(P_W-31){1'b0}}, x_in[15:0], 15'd0});
                end
            end
            S_MUL:  r_xa <= XA_W'($signed({1'b0, r_x})) * XA_W'(step_a);
            S_COMB: r_nv <= NV_W'(t_rnd);
            S_RCP:  r_q  <= (NV_W+RCP_W+1)'(r_nv)
                          * (NV_W+RCP_W+1)'($signed({1'b0, recip(ORD_W'(r_m))}));
            S_NEXT: begin
                if (!r_odd) begin
                    r_pe  <= p_new;
                    r_odd <= 1'b1;
                    r_m   <= r_m + MW'(1);
                end else begin
                    r_prev <= r_pe;
                    r_cur  <= p_new;
                    r_con  <= CON_W'(wp_rnd);
                end
            end
            S_AWR: begin
                if (k_last) begin
                    r_k <= '0;
                end else begin
                    r_k   <= r_k + CW'(1);
                    r_m   <= MW'({r_k, 1'b0}) + MW'(2);
                    r_odd <= 1'b0;
                    if (r_one) r_con <= CON_W'(r_w);
                end
            end
            S_EWAIT: begin
                if (out_free) begin
                    r_od <= acc_old;
                    r_oi <= IDX_W'(r_k);
                    r_ol <= k_last;
                    r_k  <= r_k + CW'(1);
                end
            end
            default: ;
        endcase
    end

    elca_ram #(
        .WIDTH (ACC_W),
        .DEPTH (MAX_COEFS)
    ) u_acc_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_k[AW-1:0]),
        .i_wdata (acc_new),
        .i_re    (ram_re),
        .i_raddr (r_k[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    assign o_m_tvalid = r_ov;
    assign o_m_tdata  = r_od;
    assign o_m_tuser  = r_oi;
    assign o_m_tlast  = r_ol;

`ifndef SYNTH
    // ram is never read and written in the same cycle
    a_ram_port: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(ram_we && ram_re)) else $error("accumulator ram read and write overlap");

    // coefficient counter stays inside the active count while busy
    a_k_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> (r_k < r_n)) else $error("coefficient index past count");

    // a completed flush leaves every accumulator cleared
    a_flush_clr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EWAIT && out_free && k_last) |=> (r_vld == '0))
        else $error("accumulators not cleared after flush");

    // a pair without flush never produces a result
    a_no_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_AWR && k_last && !r_fl) |=> (r_state == S_IDLE))
        else $error("emission without flush");
`endif

endmodule

/* verif/tb_top.sv */
// testbench for even_legendre_coef_accumulator_top: directed and random pairs
// with flushes, checked against an in-bench fixed-point legendre predictor
// depends on elca_pkg and the accumulator rtl
`timescale 1ns / 1ps

module tb_top;
    import elca_pkg::*;

    localparam int NCOEF = 8;
    localparam longint ACC_HI = (64'sd1 <<< 47) - 1;
    localparam longint ACC_LO = -(64'sd1 <<< 47);

    typedef struct packed {
        logic [2:0]  idx;
        logic [47:0] val;
        logic        last;
    } t_coef;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [3:0]  i_cfg_data;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [47:0] i_s_tdata;
    logic        i_s_tuser;
    logic        i_s_tlast;
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [47:0] o_m_tdata;
    logic [2:0]  o_m_tuser;
    logic        o_m_tlast;

    even_legendre_coef_accumulator_top #(.MAX_COEFS(NCOEF)) DUT (.*);

    // predictor state
    longint acc_sum[NCOEF];
    logic [3:0] count_reg;
    t_coef  coef_queue[$];
    int     mismatch_cnt;
    longint cycle_cnt;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // round half up, arithmetic shift
    function automatic longint round_shift(longint v, int sh);
        return (v + (64'sd1 <<< (sh - 1))) >>> sh;
    endfunction

    function automatic longint leg_step(longint m, longint x, longint a, longint b);
        longint rc;
        longint t;
        rc = ((64'sd1 <<< 24) + m / 2) / m;
        t = (2 * m - 1) * x * a - (m - 1) * b * 32768;
        return round_shift(round_shift(t, 15) * rc, 24);
    endfunction

    function automatic void add_sat(int k, longint v);
        longint s;
        s = acc_sum[k] + v;
        if (s > ACC_HI) s = ACC_HI;
        if (s < ACC_LO) s = ACC_LO;
        acc_sum[k] = s;
    endfunction

    function automatic int coef_total();
        if (count_reg == 0) return 1;
        if (count_reg > NCOEF) return NCOEF;
        return count_reg;
    endfunction

    // expected results of one pair transaction
    function automatic void predict_pair(logic [16:0] dot, logic [23:0] wgt,
                                         logic pv, logic fl);
        int n;
        longint x;
        longint w;
        longint pprev;
        longint pcur;
        longint pe;
        longint po;
        t_coef c;
        n = coef_total();
        if (pv) begin
            x = longint'($signed(dot));
            w = longint'($signed(wgt));
            if (x < 0) x = -x;
            if (x > 32768) x = 32768;
            if (x == 32768) begin
                for (int k = 0; k < n; k++) add_sat(k, w);
            end else begin
                pprev = 64'sd1 <<< 30;
                pcur = x <<< 15;
                add_sat(0, w);
                for (int k = 0; k + 1 < n; k++) begin
                    pe = leg_step(2 * k + 2, x, pcur, pprev);
                    po = leg_step(2 * k + 3, x, pe, pcur);
                    add_sat(k + 1, round_shift(w * pe, 30));
                    pprev = pe;
                    pcur = po;
                end
            end
        end
        if (fl) begin
            for (int k = 0; k < n; k++) begin
                c.idx = k[2:0];
                c.val = acc_sum[k][47:0];
                c.last = (k + 1 == n);
                coef_queue.push_back(c);
            end
            for (int k = 0; k < NCOEF; k++) acc_sum[k] = 0;
        end
    endfunction

    // sink with random stalls, checks each result transaction
    initial begin
        int stall;
        t_coef exp_c;
        i_m_tready = 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
            if (stall > 0) begin
                i_m_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_m_tready <= 1'b1;
            @(posedge i_clk iff o_m_tvalid);
            if (coef_queue.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                    $display("unexpected result idx=%0d val=%h", o_m_tuser, o_m_tdata);
            end else begin
                exp_c = coef_queue.pop_front();
                if (exp_c.idx !== o_m_tuser || exp_c.val !== o_m_tdata ||
                    exp_c.last !== o_m_tlast) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("mismatch: exp idx=%0d val=%h last=%b got idx=%0d val=%h last=%b",
                                 exp_c.idx, exp_c.val, exp_c.last,
                                 o_m_tuser, o_m_tdata, o_m_tlast);
                end
            end
        end
    end

    // cycle limit
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > 400000) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // valid stays high into the next transaction when there is no gap
    task automatic send_pair(logic [16:0] dot, logic [23:0] wgt, logic pv, logic fl);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata <= {7'd0, wgt, dot};
        i_s_tuser <= pv;
        i_s_tlast <= fl;
        @(posedge i_clk iff o_s_tready);
        predict_pair(dot, wgt, pv, fl);
    endtask

    // drain results, then let the block settle before a register write
    task automatic wait_idle();
        i_s_tvalid <= 1'b0;
        while (coef_queue.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    task automatic write_count(logic [3:0] v);
        wait_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk iff o_cfg_ready);
        i_cfg_valid <= 1'b0;
        count_reg = v;
    endtask

    function automatic logic [16:0] rand_dot();
        case ($urandom_range(0, 5))
            0: return 17'h08000;
            1: return 17'h18000;
            2: return 17'h0FFFF;
            default: return 17'($urandom_range(0, 131071));
        endcase
    endfunction

    function automatic logic [23:0] rand_wgt();
        case ($urandom_range(0, 4))
            0: return 24'h7FFFFF;
            1: return 24'h800000;
            default: return 24'($urandom());
        endcase
    endfunction

    // extremes of the fields, one-shortcut, out-of-range cosine, an invalid pair
    task automatic test_directed();
        send_pair(17'h00000, 24'h010000, 1, 0);
        send_pair(17'h08000, 24'h7FFFFF, 1, 0);
        send_pair(17'h18000, 24'h800000, 1, 0);
        send_pair(17'h1FFFF, 24'h123456, 1, 0);
        send_pair(17'h0FFFF, 24'hFFFFFF, 1, 0);
        send_pair(17'h10000, 24'h7FFFFF, 1, 0);
        send_pair(17'h04000, 24'h7FFFFF, 0, 1);
        send_pair(17'h00001, 24'h000001, 1, 1);
        send_pair(17'h07FFF, 24'h7FFFFF, 1, 1);
    endtask

    // repeated full-scale weights on the exact-one path
    task automatic test_saturation();
        for (int i = 0; i < 6; i++) send_pair(17'h08000, 24'h7FFFFF, 1, 0);
        send_pair(17'h08000, 24'h7FFFFF, 1, 1);
    endtask

    task automatic test_random(int items);
        for (int i = 0; i < items; i++)
            send_pair(rand_dot(), rand_wgt(), $urandom_range(0, 7) != 0,
                      $urandom_range(0, 5) == 0);
        send_pair(rand_dot(), rand_wgt(), 1, 1);
    endtask

    initial begin
        for (int k = 0; k < NCOEF; k++) acc_sum[k] = 0;
        count_reg = 4'd8;
        mismatch_cnt = 0;
        cycle_cnt = 0;
        i_rst_n <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_data <= '0;
        i_s_tvalid <= 1'b0;
        i_s_tdata <= '0;
        i_s_tuser <= 1'b0;
        i_s_tlast <= 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_saturation();
        test_random(40);
        write_count(4'd1);
        test_random(20);
        write_count(4'd0);
        send_pair(17'h03000, 24'h020000, 1, 1);
        write_count(4'd15);
        test_random(20);
        write_count(4'd3);
        test_random(25);
        write_count(4'd8);
        test_random(25);

        wait_idle();
        if (mismatch_cnt == 0 && coef_queue.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/elca_pkg.sv
rtl/elca_ram.sv
rtl/even_legendre_coef_accumulator_top.sv
verif/tb_top.sv
